>>> hdl/swtq_pkg.sv
// ----------------------------------------------------------------------------
// swtq_pkg
// shared types and constants of the sorted wakeup timer queue
// ----------------------------------------------------------------------------
package swtq_pkg;

  localparam int TASK_W        = 4;
  localparam int FIELD_TIME_W  = 64;
  localparam int MAX_TASKS_DEF = 16;
  localparam int TIME_BITS_DEF = 64;

  // a check releases at most this many tasks
  localparam int MAX_WOKEN  = 16;
  localparam int WAKE_IDX_W = $clog2(MAX_WOKEN);
  localparam int WAKE_CNT_W = $clog2(MAX_WOKEN + 1);

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ZERO_TIME = 2'd1,
    STAT_BAD_CMD   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]              command;
    logic [TASK_W-1:0]       task_req;
    logic [FIELD_TIME_W-1:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic                    woken_valid;
    logic [TASK_W-1:0]       woken_task;
    logic                    last;
    logic                    pending;
    logic [FIELD_TIME_W-1:0] earliest_wake;
    logic [1:0]              status;
  } out_item_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic              mark;
    logic              compact;
    logic              insert;
    logic              pop;
    logic [TASK_W-1:0] task_id;
  } cell_cmd_t;

  // status a cell shows to its neighbors and to the controller
  typedef struct packed {
    logic valid;
    logic gt;
    logic give;
  } cell_flags_t;

endpackage

>>> hdl/swtq_cell.sv
// ----------------------------------------------------------------------------
// swtq_cell
// one queue slot: holds a wake time and a task id, trades with its neighbors
// ----------------------------------------------------------------------------
module swtq_cell import swtq_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_cmd_t            cmd,
  input  logic [TIME_BITS-1:0] key,
  input  cell_flags_t          l_flags,
  input  logic [TIME_BITS-1:0] l_time,
  input  logic [TASK_W-1:0]    l_task,
  input  cell_flags_t          r_flags,
  input  logic [TIME_BITS-1:0] r_time,
  input  logic [TASK_W-1:0]    r_task,
  output cell_flags_t          flags,
  output logic [TIME_BITS-1:0] time_o,
  output logic [TASK_W-1:0]    task_o
);

  logic                 valid_r, valid_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [TASK_W-1:0]    task_r, task_nxt;
  logic                 gt;
  logic                 give;

  assign gt   = valid_r && (time_r > key);
  assign give = valid_r && !l_flags.valid;

  always_comb begin
    valid_nxt = valid_r;
    time_nxt  = time_r;
    task_nxt  = task_r;
    if (cmd.mark) begin
      if (valid_r && (task_r == cmd.task_id)) begin
        valid_nxt = 1'b0;
      end
    end else if (cmd.compact) begin
      // the hole moves one slot to the right per cycle
      if (!valid_r && r_flags.valid) begin
        valid_nxt = 1'b1;
        time_nxt  = r_time;
        task_nxt  = r_task;
      end else if (give) begin
        valid_nxt = 1'b0;
      end
    end else if (cmd.insert) begin
      if (l_flags.valid && l_flags.gt) begin
        valid_nxt = 1'b1;
        time_nxt  = l_time;
        task_nxt  = l_task;
      end else if (l_flags.valid && !l_flags.gt && (!valid_r || gt)) begin
        valid_nxt = 1'b1;
        time_nxt  = key;
        task_nxt  = cmd.task_id;
      end
    end else if (cmd.pop) begin
      valid_nxt = r_flags.valid;
      time_nxt  = r_time;
      task_nxt  = r_task;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    task_r <= task_nxt;
  end

  assign flags.valid = valid_r;
  assign flags.gt    = gt;
  assign flags.give  = give;
  assign time_o      = time_r;
  assign task_o      = task_r;

endmodule

>>> hdl/swtq_wake_buf.sv
// ----------------------------------------------------------------------------
// swtq_wake_buf
// short shift buffer of task ids released by one check
// ----------------------------------------------------------------------------
module swtq_wake_buf import swtq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [TASK_W-1:0]     push_task,
  input  logic                  pop,
  output logic [TASK_W-1:0]     head_task,
  output logic [WAKE_CNT_W-1:0] count
);

  logic [TASK_W-1:0]     ent_r [MAX_WOKEN];
  logic [TASK_W-1:0]     ent_nxt [MAX_WOKEN];
  logic [WAKE_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (push) begin
      ent_nxt[cnt_r[WAKE_IDX_W-1:0]] = push_task;
      cnt_nxt = cnt_r + WAKE_CNT_W'(1);
    end else if (pop) begin
      for (int i = 0; i < MAX_WOKEN - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
      cnt_nxt = cnt_r - WAKE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign head_task = ent_r[0];
  assign count     = cnt_r;

endmodule

>>> hdl/sorted_wakeup_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_wakeup_timer_queue
// task ids kept in a row of slots sorted by wake time, with set, remove, check
// ----------------------------------------------------------------------------
// The queue is a row of MAX_TASKS slots, slot 0 holding the earliest wake
// time; equal times keep arrival order. One command is worked at a time and
// in_stall stays high until its last result has gone into the output
// register. Steps per command: set and remove mark the task, then compact
// until the hole has passed the entries behind the removed task, and a set
// then inserts; check pops from slot 0 while the head is due (one pop per
// cycle), stops at a head that is not due, then gives one result per cycle
// while the output does not stall, or a single result when nothing is
// released. Bad commands and a zero wake time go straight to their result.
// Output stalls hold back every result. The hole left by a removal walks
// right one slot per cycle. Every result carries pending and earliest_wake
// as they stand after the whole command; one check releases at most 16
// tasks, the rest wait for the next check. No clearing pass after reset:
// each slot has its own valid bit.
// ----------------------------------------------------------------------------
module sorted_wakeup_timer_queue import swtq_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [TIME_BITS-1:0] NO_WAKE_TIME = '1;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_REMOVE  = 6'b000010,
    ST_COMPACT = 6'b000100,
    ST_INSERT  = 6'b001000,
    ST_POP     = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           cmd_r, cmd_nxt;
  logic [TASK_W-1:0]    task_r, task_nxt;
  logic [TIME_BITS-1:0] key_r, key_nxt;
  status_t              status_r, status_nxt;

  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t emit_data;

  logic in_fire;
  logic out_load;
  logic emit;
  logic wake_push;
  logic wake_pop;

  cell_cmd_t            ccmd;
  cell_flags_t          cflags    [MAX_TASKS];
  logic [TIME_BITS-1:0] cell_time [MAX_TASKS];
  logic [TASK_W-1:0]    cell_task [MAX_TASKS];
  logic [MAX_TASKS-1:0] give_vec;

  logic                  full;
  logic                  any_give;
  logic                  head_due;
  logic                  can_pop;
  logic [TIME_BITS-1:0]  in_time;
  logic [TASK_W-1:0]     wake_head;
  logic [WAKE_CNT_W-1:0] wake_cnt;

  // --------------------------------------------------------------------------
  // row of slots
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    cell_flags_t          lf, rf;
    logic [TIME_BITS-1:0] lt, rt;
    logic [TASK_W-1:0]    ltk, rtk;

    // slot 0 sees a filled, never-later neighbor on its left
    if (i == 0) begin : g_left_edge
      assign lf  = '{valid: 1'b1, gt: 1'b0, give: 1'b0};
      assign lt  = '0;
      assign ltk = '0;
    end else begin : g_left
      assign lf  = cflags[i-1];
      assign lt  = cell_time[i-1];
      assign ltk = cell_task[i-1];
    end

    // past the last slot the row is empty
    if (i == MAX_TASKS - 1) begin : g_right_edge
      assign rf  = '0;
      assign rt  = '0;
      assign rtk = '0;
    end else begin : g_right
      assign rf  = cflags[i+1];
      assign rt  = cell_time[i+1];
      assign rtk = cell_task[i+1];
    end

    swtq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (ccmd),
      .key     (key_r),
      .l_flags (lf),
      .l_time  (lt),
      .l_task  (ltk),
      .r_flags (rf),
      .r_time  (rt),
      .r_task  (rtk),
      .flags   (cflags[i]),
      .time_o  (cell_time[i]),
      .task_o  (cell_task[i])
    );

    assign give_vec[i] = cflags[i].give;
  end

  // --------------------------------------------------------------------------
  // released task ids wait here until the results go out
  // --------------------------------------------------------------------------
  swtq_wake_buf u_wake_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (wake_push),
    .push_task (cell_task[0]),
    .pop       (wake_pop),
    .head_task (wake_head),
    .count     (wake_cnt)
  );

  // --------------------------------------------------------------------------
  // command sequencer
  // --------------------------------------------------------------------------
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = !out_valid_r || !out_stall;
  assign in_time  = in_data.time_value[TIME_BITS-1:0];

  assign full     = cflags[MAX_TASKS-1].valid;
  assign any_give = |give_vec;
  assign head_due = cflags[0].valid && !cflags[0].gt;
  assign can_pop  = head_due && (wake_cnt < WAKE_CNT_W'(MAX_WOKEN));

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    task_nxt     = task_r;
    key_nxt      = key_r;
    status_nxt   = status_r;
    ccmd         = '0;
    ccmd.task_id = task_r;
    wake_push    = 1'b0;
    wake_pop     = 1'b0;
    emit         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt    = in_data.command;
          task_nxt   = in_data.task_req;
          key_nxt    = in_time;
          status_nxt = STAT_OK;
          case (in_data.command)
            CMD_SET: begin
              if (in_time == '0) begin
                status_nxt = STAT_ZERO_TIME;
                state_nxt  = ST_EMIT;
              end else begin
                state_nxt = ST_REMOVE;
              end
            end
            CMD_REMOVE: state_nxt = ST_REMOVE;
            CMD_CHECK:  state_nxt = ST_POP;
            default: begin
              status_nxt = STAT_BAD_CMD;
              state_nxt  = ST_EMIT;
            end
          endcase
        end
      end
      ST_REMOVE: begin
        ccmd.mark = 1'b1;
        state_nxt = ST_COMPACT;
      end
      ST_COMPACT: begin
        ccmd.compact = 1'b1;
        if (!any_give) begin
          state_nxt = (cmd_r == CMD_SET) ? ST_INSERT : ST_EMIT;
        end
      end
      ST_INSERT: begin
        // a set on a full row is dropped
        ccmd.insert = !full;
        state_nxt   = ST_EMIT;
      end
      ST_POP: begin
        if (can_pop) begin
          ccmd.pop  = 1'b1;
          wake_push = 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          emit     = 1'b1;
          wake_pop = (wake_cnt != '0);
          if (wake_cnt <= WAKE_CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result fields; pending and earliest_wake come from slot 0 after the command
  always_comb begin
    emit_data               = '0;
    emit_data.woken_valid   = (wake_cnt != '0);
    emit_data.woken_task    = (wake_cnt != '0) ? wake_head : '0;
    emit_data.last          = (wake_cnt <= WAKE_CNT_W'(1));
    emit_data.pending       = cflags[0].valid;
    emit_data.earliest_wake = cflags[0].valid ? FIELD_TIME_W'(cell_time[0])
                                              : FIELD_TIME_W'(NO_WAKE_TIME);
    emit_data.status        = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    task_r   <= task_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // between commands the filled slots form one unbroken run from slot 0
  a_row_packed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !any_give)
    else $error("queue slots not packed while idle");

  // an empty queue always reports the all-ones wake time
  a_empty_reports_inf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.pending) |->
      (out_data_r.earliest_wake == FIELD_TIME_W'(NO_WAKE_TIME)))
    else $error("empty queue reported a wake time");

  // a result without a released task closes its command
  a_empty_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.woken_valid) |-> out_data_r.last)
    else $error("result without task not flagged last");

  // a command ends only with its last result in the output register
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r == ST_EMIT) && (state_r == ST_IDLE)) |->
      (out_valid_r && out_data_r.last))
    else $error("command finished without a last result");

endmodule

>>> test/sorted_wakeup_timer_queue_tb.sv
// ----------------------------------------------------------------------------
// sorted_wakeup_timer_queue_tb
// self-checking bench for the sorted wakeup timer queue
// ----------------------------------------------------------------------------
// A driver pushes set, remove, check and illegal commands from a backlog
// into the block. A scoreboard model of the sorted slot row predicts every
// result transfer. A monitor compares each result transfer field by field
// with the oldest prediction. Both sides idle in random bursts. The result
// side also holds off once for a long stretch, so the block backs up and
// stalls its input. The stimulus is a directed opening followed by random
// traffic around a moving "now".
// ----------------------------------------------------------------------------
module sorted_wakeup_timer_queue_tb;
  import swtq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_TASKS    = MAX_TASKS_DEF;
  localparam int          TIME_BITS    = TIME_BITS_DEF;
  localparam logic [63:0] TIME_MASK    = {64{1'b1}} >> (64 - TIME_BITS);
  localparam logic [63:0] NO_WAKE_TIME = TIME_MASK;
  // command code the block has no meaning for
  localparam logic [1:0]  CMD_ILLEGAL  = 2'd3;
  localparam int          RANDOM_CMDS  = 250;
  localparam int          CALM_TAIL    = 40;   // backlog depth below which nobody idles
  localparam int          HOLD_CYCLES  = 250;  // long receiver hold-off
  localparam int          DRAIN_WAIT   = 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic      hold_off  = 1'b0;
  logic      calm_tail = 1'b0;

  // commands waiting to be offered, and result transfers the model says are due
  in_item_t  cmd_backlog [$];
  out_item_t due_reports [$];

  // scoreboard copy of the slot row
  logic [63:0]       q_time [MAX_TASKS];
  logic [TASK_W-1:0] q_task [MAX_TASKS];
  int                q_len = 0;

  int total_cmds   = 0;
  int cmds_taken   = 0;
  int reports_seen = 0;
  int woken_seen   = 0;
  int release_run  = 0;
  int longest_run  = 0;
  int fault_n      = 0;
  int in_gap       = 0;
  int out_gap      = 0;

  always #5 clk = ~clk;

  sorted_wakeup_timer_queue #(
    .MAX_TASKS(MAX_TASKS),
    .TIME_BITS(TIME_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  task automatic flag_error(input string msg);
    fault_n++;
    if (fault_n <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  function automatic void add_cmd(input logic [1:0] c, input logic [TASK_W-1:0] id,
                                  input logic [63:0] tv);
    in_item_t item;
    item.command    = c;
    item.task_req   = id;
    item.time_value = tv;
    cmd_backlog.push_back(item);
  endfunction

  // pending and earliest_wake reflect the row after the whole command
  function automatic void push_report(input logic v, input logic [TASK_W-1:0] id,
                                      input logic lst, input status_t st);
    out_item_t r;
    r.woken_valid   = v;
    r.woken_task    = id;
    r.last          = lst;
    r.pending       = (q_len != 0);
    r.earliest_wake = (q_len != 0) ? q_time[0] : NO_WAKE_TIME;
    r.status        = st;
    due_reports.push_back(r);
  endfunction

  // take a task out of the row and close the hole behind it
  function automatic void drop_task(input logic [TASK_W-1:0] id);
    int i, j;
    for (i = 0; i < q_len; i++) begin
      if (q_task[i] == id) begin
        for (j = i; j + 1 < q_len; j++) begin
          q_time[j] = q_time[j + 1];
          q_task[j] = q_task[j + 1];
        end
        q_len--;
        return;
      end
    end
  endfunction

  // insert after every entry with an equal or earlier time, ignored when full
  function automatic void place_task(input logic [TASK_W-1:0] id, input logic [63:0] tv);
    int pos, j;
    if (q_len >= MAX_TASKS) return;
    pos = 0;
    while (pos < q_len && q_time[pos] <= tv) pos++;
    for (j = q_len; j > pos; j--) begin
      q_time[j] = q_time[j - 1];
      q_task[j] = q_task[j - 1];
    end
    q_time[pos] = tv;
    q_task[pos] = id;
    q_len++;
  endfunction

  // apply one accepted command to the row and queue its result transfers
  function automatic void run_queue_cmd(input in_item_t c);
    logic [63:0]       tv;
    logic [TASK_W-1:0] woken [MAX_WOKEN];
    int                n, j;
    tv = c.time_value & TIME_MASK;
    n  = 0;
    case (c.command)
      CMD_SET: begin
        if (tv == '0) begin
          push_report(1'b0, '0, 1'b1, STAT_ZERO_TIME);
        end else begin
          drop_task(c.task_req);
          place_task(c.task_req, tv);
          push_report(1'b0, '0, 1'b1, STAT_OK);
        end
      end
      CMD_REMOVE: begin
        drop_task(c.task_req);
        push_report(1'b0, '0, 1'b1, STAT_OK);
      end
      CMD_CHECK: begin
        // pop from the head while due, at most one burst's worth
        while (n < q_len && n < MAX_WOKEN && q_time[n] <= tv) begin
          woken[n] = q_task[n];
          n++;
        end
        for (j = 0; j + n < q_len; j++) begin
          q_time[j] = q_time[j + n];
          q_task[j] = q_task[j + n];
        end
        q_len -= n;
        if (n == 0) begin
          push_report(1'b0, '0, 1'b1, STAT_OK);
        end else begin
          for (j = 0; j < n; j++) push_report(1'b1, woken[j], (j == n - 1), STAT_OK);
        end
      end
      default: begin
        push_report(1'b0, '0, 1'b1, STAT_BAD_CMD);
      end
    endcase
  endfunction

  // driver: predict on each input transfer, then offer the next command or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        run_queue_cmd(in_data);
        cmds_taken++;
      end
      // payload only moves when nothing is held on the port
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
          // start an idle burst, this cycle included; in_gap counts down the rest
          in_gap = $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          in_data  <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      calm_tail <= (cmd_backlog.size() < CALM_TAIL);
    end
  end

  // monitor: check each result transfer, then choose the next stall value
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (due_reports.size() == 0) begin
          flag_error($sformatf("unexpected result transfer v=%0b task=%0d last=%0b st=%0d",
                               out_data.woken_valid, out_data.woken_task, out_data.last,
                               out_data.status));
        end else begin
          want = due_reports.pop_front();
          if (out_data.woken_valid   !== want.woken_valid   ||
              out_data.woken_task    !== want.woken_task    ||
              out_data.last          !== want.last          ||
              out_data.pending       !== want.pending       ||
              out_data.earliest_wake !== want.earliest_wake ||
              out_data.status        !== want.status) begin
            flag_error($sformatf({"result mismatch: exp v=%0b task=%0d last=%0b pend=%0b ",
                                  "next=%h st=%0d, got v=%0b task=%0d last=%0b pend=%0b ",
                                  "next=%h st=%0d"},
                                 want.woken_valid, want.woken_task, want.last,
                                 want.pending, want.earliest_wake, want.status,
                                 out_data.woken_valid, out_data.woken_task, out_data.last,
                                 out_data.pending, out_data.earliest_wake, out_data.status));
          end
        end
        // track the longest run of released tasks from one check
        if (out_data.woken_valid === 1'b1) begin
          woken_seen++;
          release_run++;
        end
        if (out_data.last === 1'b1) begin
          if (release_run > longest_run) longest_run = release_run;
          release_run = 0;
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering, so the block backs up
  initial begin
    while (cmds_taken < 60) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [63:0]       now_t;
    logic [63:0]       tv;
    logic [TASK_W-1:0] id;
    int                pick, sel, i;

    // directed opening
    add_cmd(CMD_CHECK, 4'd0, 64'd0);          // check on an empty row
    add_cmd(CMD_REMOVE, 4'd5, NO_WAKE_TIME);  // remove of a task that is not queued
    add_cmd(CMD_SET, 4'd3, 64'd0);            // zero wake time is rejected
    add_cmd(CMD_ILLEGAL, 4'hF, NO_WAKE_TIME); // illegal command
    add_cmd(CMD_SET, 4'd0, NO_WAKE_TIME);     // latest possible time
    add_cmd(CMD_SET, 4'd15, 64'd1);           // earliest possible time
    add_cmd(CMD_SET, 4'd7, 64'd100);          // three equal times keep arrival order
    add_cmd(CMD_SET, 4'd8, 64'd100);
    add_cmd(CMD_SET, 4'd9, 64'd100);
    add_cmd(CMD_SET, 4'd8, 64'd100);          // re-set moves behind its equals
    add_cmd(CMD_SET, 4'd15, 64'd50);          // re-set of a queued task moves it
    add_cmd(CMD_REMOVE, 4'd7, 64'd0);
    add_cmd(CMD_CHECK, 4'd0, 64'd99);
    add_cmd(CMD_CHECK, 4'd0, 64'd100);        // several tasks released at once
    // fill every slot, then re-set a queued task while full
    for (i = 1; i < MAX_TASKS; i++) add_cmd(CMD_SET, TASK_W'(i), 64'(200 - 10 * (i % 3)));
    add_cmd(CMD_SET, 4'd5, 64'd1);
    add_cmd(CMD_CHECK, 4'd0, NO_WAKE_TIME);   // release the whole row

    // random traffic around a moving current time
    now_t = 64'd1000;
    for (i = 0; i < RANDOM_CMDS; i++) begin
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 19);
      id   = TASK_W'($urandom_range(0, 15));
      if (pick < 45) begin
        if (sel == 0) tv = 64'd0;
        else if (sel == 1) tv = {$urandom, $urandom};
        else if (sel < 7) tv = now_t + 64'(8 * $urandom_range(1, 6));  // coarse grid, ties
        else tv = now_t + 64'($urandom_range(1, 300));
        add_cmd(CMD_SET, id, tv);
      end else if (pick < 62) begin
        add_cmd(CMD_REMOVE, id, {$urandom, $urandom});
      end else if (pick < 95) begin
        if (sel == 0) begin
          tv = NO_WAKE_TIME;
        end else if (sel == 1) begin
          tv = {$urandom, $urandom};
        end else begin
          now_t = now_t + 64'($urandom_range(0, 120));
          tv    = now_t;
        end
        add_cmd(CMD_CHECK, id, tv);
      end else begin
        add_cmd(CMD_ILLEGAL, id, {$urandom, $urandom});
      end
    end
    total_cmds = cmd_backlog.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // every command taken and every predicted transfer seen
    while (cmds_taken < total_cmds || due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (due_reports.size() != 0) begin
      flag_error($sformatf("%0d predicted result transfers never arrived",
                           due_reports.size()));
    end

    $display("covered %0d commands (directed, random set/remove/check, illegal, zero time)",
             cmds_taken);
    $display("seen %0d result transfers, %0d tasks released, longest release burst %0d",
             reports_seen, woken_seen, longest_run);
    if (fault_n == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
